// ----- design/itst_pkg.sv -----
// Package: shared constants, payload structs, state codes and control bundles.
`timescale 1ns / 1ps

package itst_pkg;

    // Table geometry
    localparam int SLOTS     = 32;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int EXT_W     = $clog2(SLOTS + 1);
    localparam int KEY_W     = 64;
    localparam int PROG_W    = 16;
    localparam int IDX_OUT_W = 6;

    // Event kinds
    localparam logic FUNC_SUBMIT   = 1'b0;
    localparam logic FUNC_COMPLETE = 1'b1;

    typedef enum logic [2:0] {
        GLYPH_LINE  = 3'd0,
        GLYPH_CROSS = 3'd1,
        GLYPH_OPEN  = 3'd2,
        GLYPH_CLOSE = 3'd3,
        GLYPH_BLANK = 3'd4,
        GLYPH_VERT  = 3'd5
    } glyph_t;

    typedef struct packed {
        logic              func;
        logic [KEY_W-1:0]  tag_key;
        logic [PROG_W-1:0] program_id;
        logic              rw;
    } evt_in_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] slot_index;
        logic [PROG_W-1:0]    prog_out;
        logic                 dir_out;
        logic [IDX_OUT_W-1:0] column;
        glyph_t               glyph;
        logic                 overflow;
        logic                 last;
    } evt_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUBMIT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_EMIT,
        ST_SHRINK
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // latch a new transaction
        logic alloc;      // claim the lowest free column
        logic ovf_out;    // send the table-full result
        logic scan_inc;   // advance the tag scan
        logic free_hit;   // release the matching column
        logic emit;       // send one glyph result
        logic shrink_dec; // drop one trailing free column
    } itst_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_complete;
        logic free_any;
        logic scan_end;
        logic hit;
        logic emit_last;
        logic shrink_more;
    } itst_stat_t;

endpackage

// ----- design/io_tag_slot_tracker_unit.sv -----
// Top level: tracker of in-flight I/O tags, controller plus datapath.
//
//  Channel   Ports                          Transfer
//  --------  -----------------------------  ---------------------------------
//  request   start, busy, request           start high while busy low
//  result    result_strobe, result          strobe with each result, no stall
//
// A submit claims the lowest free column and sends one result per column up to
// the used extent, or a table-full result if none is free. A complete scans the
// tag memory (registered read, then compare), emits one result per column on a
// hit (none for an unknown tag), then drops one trailing free column per cycle.
// Reset clears every valid bit and the extent at once; no clearing pass is
// needed. Results leave through a register; the receiver cannot hold them off.
`timescale 1ns / 1ps

module io_tag_slot_tracker_unit
    import itst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  evt_in_t  request,
    output evt_out_t result,
    output logic     result_strobe
);

    itst_cmd_t  cmd;
    itst_stat_t stat;
    logic       ctrl_busy;

    // Sequence each transaction
    itst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (ctrl_busy)
    );

    // Hold the table and build results
    itst_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .cmd           (cmd),
        .stat          (stat),
        .result        (result),
        .result_strobe (result_strobe)
    );

    assign busy = ctrl_busy;

endmodule

// ----- design/itst_ctrl.sv -----
// Controller: sequences lookup, glyph emission and extent shrink per transaction.
`timescale 1ns / 1ps

module itst_ctrl
    import itst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  itst_stat_t stat,
    output itst_cmd_t  cmd,
    output logic       busy
);

    ctrl_state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pick next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SUBMIT;
                end
            end
            ST_SUBMIT:
            begin
                if (stat.is_complete)
                begin
                    state_next = ST_SCAN_RD;
                end
                else if (stat.free_any)
                begin
                    cmd.alloc  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.ovf_out = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                // Unknown tag: drop the transaction without a result
                if (stat.scan_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP:
            begin
                if (stat.hit)
                begin
                    cmd.free_hit = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = ST_SCAN_RD;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (stat.emit_last)
                begin
                    state_next = stat.is_complete ? ST_SHRINK : ST_IDLE;
                end
            end
            ST_SHRINK:
            begin
                if (stat.shrink_more)
                begin
                    cmd.shrink_dec = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- design/itst_dp.sv -----
// Datapath: slot table, tag and program memories, extent, counters and result register.
`timescale 1ns / 1ps

module itst_dp
    import itst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  evt_in_t    request,
    input  itst_cmd_t  cmd,
    output itst_stat_t stat,
    output evt_out_t   result,
    output logic       result_strobe
);

    // Transaction fields
    logic              func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [PROG_W-1:0] prog_in_reg;
    logic              rw_reg;

    // Table state and counters
    logic [SLOTS-1:0]  valid_reg;
    logic [EXT_W-1:0]  extent_reg;
    logic [EXT_W-1:0]  scan_reg;
    logic [EXT_W-1:0]  col_reg;

    // Row description for the glyph pass
    logic [SLOT_W-1:0] ev_col_reg;
    logic [PROG_W-1:0] ev_prog_reg;
    logic              ev_dir_reg;
    glyph_t            corner_reg;

    // Memories and registered read data
    logic [KEY_W-1:0]  tag_mem  [SLOTS];
    logic [PROG_W-1:0] prog_mem [SLOTS];
    logic [KEY_W-1:0]  tag_rd_reg;
    logic [PROG_W-1:0] prog_rd_reg;

    evt_out_t          result_reg, result_next;
    logic              strobe_reg;

    logic [SLOTS-1:0]  free_vec;
    logic [SLOTS-1:0]  free_oh;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] scan_idx;
    logic [SLOT_W-1:0] col_idx;
    logic [EXT_W-1:0]  ext_m1;
    logic [EXT_W-1:0]  col_p1;
    glyph_t            glyph_cur;

    // Find the lowest free column
    always_comb
    begin
        free_vec = ~valid_reg;
        free_oh  = free_vec & (~free_vec + SLOTS'(1));
        free_idx = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (free_oh[k])
            begin
                free_idx = free_idx | SLOT_W'(k);
            end
        end
    end

    assign scan_idx = scan_reg[SLOT_W-1:0];
    assign col_idx  = col_reg[SLOT_W-1:0];
    assign ext_m1   = extent_reg - EXT_W'(1);
    assign col_p1   = col_reg + EXT_W'(1);

    // Classify the current column
    always_comb
    begin
        if (col_idx < ev_col_reg)
        begin
            glyph_cur = valid_reg[col_idx] ? GLYPH_CROSS : GLYPH_LINE;
        end
        else if (col_idx == ev_col_reg)
        begin
            glyph_cur = corner_reg;
        end
        else
        begin
            glyph_cur = valid_reg[col_idx] ? GLYPH_VERT : GLYPH_BLANK;
        end
    end

    // Report status
    always_comb
    begin
        stat.is_complete = (func_reg == FUNC_COMPLETE);
        stat.free_any    = |free_vec;
        stat.scan_end    = (scan_reg >= extent_reg);
        stat.hit         = valid_reg[scan_idx] && (tag_rd_reg == key_reg);
        stat.emit_last   = (col_p1 == extent_reg);
        stat.shrink_more = (extent_reg != '0) && !valid_reg[ext_m1[SLOT_W-1:0]];
    end

    // Build the next result
    always_comb
    begin
        result_next = result_reg;
        if (cmd.ovf_out)
        begin
            result_next.slot_index = '0;
            result_next.prog_out   = prog_in_reg;
            result_next.dir_out    = rw_reg;
            result_next.column     = '0;
            result_next.glyph      = GLYPH_BLANK;
            result_next.overflow   = 1'b1;
            result_next.last       = 1'b1;
        end
        else if (cmd.emit)
        begin
            result_next.slot_index = IDX_OUT_W'(ev_col_reg);
            result_next.prog_out   = ev_prog_reg;
            result_next.dir_out    = ev_dir_reg;
            result_next.column     = IDX_OUT_W'(col_idx);
            result_next.glyph      = glyph_cur;
            result_next.overflow   = 1'b0;
            result_next.last       = (col_p1 == extent_reg);
        end
    end

    // Update control state: valid bits, extent, counters, strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            extent_reg <= '0;
            scan_reg   <= '0;
            col_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit | cmd.ovf_out;
            if (cmd.load)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_inc)
            begin
                scan_reg <= scan_reg + EXT_W'(1);
            end
            if (cmd.alloc)
            begin
                valid_reg[free_idx] <= 1'b1;
                col_reg             <= '0;
                if (extent_reg <= EXT_W'(free_idx))
                begin
                    extent_reg <= EXT_W'(free_idx) + EXT_W'(1);
                end
            end
            else if (cmd.free_hit)
            begin
                valid_reg[scan_idx] <= 1'b0;
                col_reg             <= '0;
            end
            else if (cmd.emit)
            begin
                col_reg <= col_p1;
            end
            else if (cmd.shrink_dec)
            begin
                extent_reg <= ext_m1;
            end
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (cmd.load)
        begin
            func_reg    <= request.func;
            key_reg     <= request.tag_key;
            prog_in_reg <= request.program_id;
            rw_reg      <= request.rw;
        end
        if (cmd.alloc)
        begin
            ev_col_reg  <= free_idx;
            ev_prog_reg <= prog_in_reg;
            ev_dir_reg  <= rw_reg;
            corner_reg  <= GLYPH_OPEN;
        end
        else if (cmd.free_hit)
        begin
            ev_col_reg  <= scan_idx;
            ev_prog_reg <= prog_rd_reg;
            ev_dir_reg  <= 1'b0;
            corner_reg  <= GLYPH_CLOSE;
        end
    end

    // Tag and program memories: write on claim, read at the scan address
    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
        begin
            tag_mem[free_idx]  <= key_reg;
            prog_mem[free_idx] <= prog_in_reg;
        end
        tag_rd_reg  <= tag_mem[scan_idx];
        prog_rd_reg <= prog_mem[scan_idx];
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule
